>>> hdl/periodic_can_frame_scheduler_macros.svh
// Assertion macros for the periodic CAN frame scheduler.
`ifndef PERIODIC_CAN_FRAME_SCHEDULER_MACROS_SVH
`define PERIODIC_CAN_FRAME_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;
    localparam int TASKS = 8;
    localparam int SLOT_W = 3;
    localparam int MAX_SENDS = 8;
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    localparam logic [1:0] REG_SPECIAL_SLOT = 2'd0;
    localparam logic [1:0] REG_HV_STATUS = 2'd1;
    localparam logic [1:0] REG_ALIVE_LIMIT = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;        // write the input item into its slot
        logic tick_start;  // latch time and FIFO space, clear counters
        logic eval;        // read current slot, evaluate due, apply special packing
        logic send;        // load the output register with the current slot
        logic empty;       // load the output register with the empty marker
        logic crc_start;   // begin byte-serial CRC on the current slot
        logic crc_step;    // fold one payload byte into the CRC
        logic crc_write;   // write back the updated payload
        logic next_slot;   // advance the slot index
        logic out_last;    // mark the output frame as last
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic due;         // current slot is valid and due
        logic can_send;    // FIFO space and send budget remain
        logic special;     // current slot is the special slot
        logic crc_done;    // all CRC bytes folded
        logic last_slot;   // current slot index is the final one
        logic more_due;    // a later slot will produce a frame
        logic any_sent;    // at least one frame sent in this tick
    } t_sts;

    // One CRC8 SAE J1850 byte step.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction
endpackage
`default_nettype wire

>>> hdl/pcs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_datapath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire pcs_pkg::t_cmd            i_cmd,
    output pcs_pkg::t_sts                 o_sts,
    input  wire [pcs_pkg::SLOT_W-1:0]     i_slot,
    input  wire [10:0]                    i_frame_id,
    input  wire [15:0]                    i_send_period,
    input  wire [3:0]                     i_frame_len,
    input  wire [63:0]                    i_payload,
    input  wire                           i_use_alive,
    input  wire                           i_use_crc,
    input  wire [31:0]                    i_now_ms,
    input  wire [3:0]                     i_fifo_space,
    input  wire [2:0]                     i_special_slot,
    input  wire [2:0]                     i_hv_status,
    input  wire [4:0]                     i_alive_limit,
    output logic [82:0]                   o_frame,
    output logic                          o_frame_last
);
    localparam int NT = pcs_pkg::TASKS;

    // Slot table.
    logic [NT-1:0]  r_valid, r_force;
    logic [10:0]    r_id     [NT];
    logic [15:0]    r_period [NT];
    logic [3:0]     r_len    [NT];
    logic [1:0]     r_flags  [NT];
    logic [63:0]    r_pay    [NT];
    logic [31:0]    r_next   [NT];
    logic [4:0]     r_alive;

    // Tick context.
    logic [31:0]    r_now;
    logic [3:0]     r_space;
    logic [3:0]     r_sent;
    logic [pcs_pkg::SLOT_W-1:0] r_idx;

    // CRC engine.
    logic [7:0]     r_crc;
    logic [2:0]     r_crc_k;
    logic [2:0]     r_crc_cnt;
    logic [63:0]    r_work;

    logic [31:0]    w_diff;
    logic           w_due;
    logic           w_special;
    logic [63:0]    w_packed;
    logic [7:0]     w_b1, w_b2;
    logic [NT-1:0]  w_due_vec;

    // Due vector for lookahead of last frame.
    always_comb begin
        logic [31:0] d;
        d = '0;
        for (int i = 0; i < NT; i++) begin
            d = r_now - r_next[i];
            w_due_vec[i] = r_valid[i] && (r_force[i] || !d[31]);
        end
    end

    assign w_diff    = r_now - r_next[r_idx];
    assign w_due     = r_valid[r_idx] && (r_force[r_idx] || !w_diff[31]);
    assign w_special = ({1'b0, r_idx} == {1'b0, i_special_slot});

    // Special packing of alive and status bits (CRC computed serially after).
    always_comb begin
        w_b1 = {i_hv_status[1], i_hv_status[0], r_pay[r_idx][13], r_alive};
        w_b2 = {r_pay[r_idx][23:17], i_hv_status[2]};
        w_packed = {r_pay[r_idx][63:24], w_b2, w_b1, r_pay[r_idx][7:0]};
    end

    always_comb begin
        logic [3:0] rem;
        logic       more;
        rem  = r_space - 4'd1;
        more = 1'b0;
        for (int i = 0; i < NT; i++) begin
            if (i > int'(r_idx) && w_due_vec[i]) more = 1'b1;
        end
        o_sts.due       = w_due;
        o_sts.can_send  = (r_space != 4'd0) && (r_sent < 4'(pcs_pkg::MAX_SENDS));
        o_sts.special   = w_special;
        o_sts.crc_done  = (r_crc_k >= r_crc_cnt);
        o_sts.last_slot = (r_idx == pcs_pkg::SLOT_W'(NT - 1));
        o_sts.more_due  = more && (rem != 4'd0) && (r_sent + 4'd1 < 4'(pcs_pkg::MAX_SENDS));
        o_sts.any_sent  = (r_sent != 4'd0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_force <= '0;
            r_alive <= '0;
            r_sent  <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_valid[i_slot] <= 1'b1;
                r_force[i_slot] <= 1'b1;
            end
            if (i_cmd.tick_start) begin
                r_sent <= '0;
                r_idx  <= '0;
            end
            if (i_cmd.send) begin
                r_sent <= r_sent + 4'd1;
                r_force[r_idx] <= 1'b0;
                if (w_special) begin
                    r_alive <= (r_alive >= i_alive_limit) ? 5'd0 : r_alive + 5'd1;
                end
            end
            if (i_cmd.next_slot) r_idx <= r_idx + 1'b1;
        end
    end

    // Payload storage and datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id[i_slot]     <= i_frame_id;
            r_period[i_slot] <= i_send_period;
            r_len[i_slot]    <= i_frame_len;
            r_flags[i_slot]  <= {i_use_crc, i_use_alive};
            r_pay[i_slot]    <= i_payload;
        end
        if (i_cmd.tick_start) begin
            r_now   <= i_now_ms;
            r_space <= i_fifo_space;
        end
        if (i_cmd.eval && w_special) r_pay[r_idx] <= w_packed;
        if (i_cmd.send) begin
            r_space       <= r_space - 4'd1;
            r_next[r_idx] <= r_now + {16'd0, r_period[r_idx]};
            o_frame <= {r_pay[r_idx], r_len[r_idx], r_id[r_idx], r_idx, 1'b1};
            o_frame_last <= i_cmd.out_last;
        end
        if (i_cmd.empty) begin
            o_frame      <= 83'd0;
            o_frame_last <= 1'b1;
        end
        // CRC work copy: special uses seven bytes of the packed payload,
        // ordinary len-1 clamped.
        if (i_cmd.crc_start) begin
            r_crc   <= pcs_pkg::CRC_INIT;
            r_crc_k <= 3'd0;
            if (w_special) begin
                r_work    <= w_packed;
                r_crc_cnt <= 3'd7;
            end else begin
                r_work <= r_flags[r_idx][0]
                    ? {r_pay[r_idx][63:16], 4'd0, r_pay[r_idx][11:8] + 4'd1,
                       r_pay[r_idx][7:0]}
                    : r_pay[r_idx];
                r_crc_cnt <= !r_flags[r_idx][1] ? 3'd0 :
                    (r_len[r_idx] == 4'd0) ? 3'd0 :
                    (r_len[r_idx] > 4'd8) ? 3'd7 : 3'(r_len[r_idx] - 4'd1);
            end
        end
        if (i_cmd.crc_step) begin
            r_crc   <= pcs_pkg::crc_byte(r_crc, r_work[8*(int'(r_crc_k)+1) +: 8]);
            r_crc_k <= r_crc_k + 3'd1;
        end
        if (i_cmd.crc_write) begin
            if (w_special || r_flags[r_idx][1]) begin
                r_pay[r_idx] <= {r_work[63:8], r_crc ^ pcs_pkg::CRC_XOROUT};
            end else begin
                r_pay[r_idx] <= r_work;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/pcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_func,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire pcs_pkg::t_sts  i_sts,
    output pcs_pkg::t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_PCRC   = 7'b0000100,
        S_PWR    = 7'b0001000,
        S_OUT    = 7'b0010000,
        S_UCRC   = 7'b0100000,
        S_UWR    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_was_special, n_was_special;

    assign o_in_ready  = (r_state == S_IDLE) && !r_valid;
    assign o_out_valid = r_valid;

    // Sequencer over the slots of one tick.
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        n_was_special = r_was_special;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in_func == pcs_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (i_sts.due) begin
                    o_cmd.eval = 1'b1;
                    if (i_sts.special) begin
                        o_cmd.crc_start = 1'b1;
                        n_state = S_PCRC;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_sts.last_slot) begin
                    if (!i_sts.any_sent) begin
                        if (!r_valid || i_out_ready) begin
                            o_cmd.empty = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.next_slot = 1'b1;
                end
            end
            S_PCRC: begin
                if (i_sts.crc_done) n_state = S_PWR;
                else o_cmd.crc_step = 1'b1;
            end
            S_PWR: begin
                o_cmd.crc_write = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.can_send) begin
                    n_state = S_EVAL;
                    if (i_sts.last_slot) begin
                        if (!i_sts.any_sent) begin
                            if (!r_valid || i_out_ready) begin
                                o_cmd.empty = 1'b1;
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_OUT;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.next_slot = 1'b1;
                    end
                end else if (!r_valid || i_out_ready) begin
                    o_cmd.send = 1'b1;
                    o_cmd.out_last = !i_sts.more_due;
                    n_valid = 1'b1;
                    n_was_special = i_sts.special;
                    o_cmd.crc_start = 1'b1;
                    n_state = S_UCRC;
                end
            end
            S_UCRC: begin
                if (r_was_special || i_sts.crc_done) n_state = S_UWR;
                else o_cmd.crc_step = 1'b1;
            end
            S_UWR: begin
                if (!r_was_special) o_cmd.crc_write = 1'b1;
                if (i_sts.last_slot) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state = S_EVAL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_was_special <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_was_special <= n_was_special;
        end
    end
endmodule
`default_nettype wire

>>> hdl/periodic_can_frame_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Periodic CAN frame scheduler. Load requests (tuser func 0) write a task slot
// and produce no result; tick requests (func 1) scan the eight slots in order
// and emit one result per sent frame, tlast on the final one, or a single empty
// marker when nothing is sent. A tick evaluates each slot in turn; each due
// slot is sent and then has its payload updated, with byte-serial CRC8 in the
// shared CRC unit, and the special slot is packed and given its CRC before
// it is sent; a send waits while the previous result is still held. A new
// request is taken once the scan is over and the last result has been taken.
`include "periodic_can_frame_scheduler_macros.svh"
module periodic_can_frame_scheduler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: slot[2:0], frame_id[13:3], send_period[29:14], frame_len[33:30],
    // payload[97:34], use_alive[98], use_crc[99], now_ms[131:100],
    // fifo_space[135:132]
    input  wire [135:0] s_axis_tdata,
    // tuser: func
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: frame_valid[0], sent_slot[3:1], sent_id[14:4], sent_len[18:15],
    // sent_payload[82:19], zero fill up to 87
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_index,
    input  wire [4:0]   i_cfg_data
);
    pcs_pkg::t_cmd w_cmd;
    pcs_pkg::t_sts w_sts;
    logic [2:0] r_special_slot, r_hv_status;
    logic [4:0] r_alive_limit;
    logic [82:0] w_frame;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special_slot <= 3'd2;
            r_hv_status    <= 3'd1;
            r_alive_limit  <= 5'd14;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcs_pkg::REG_SPECIAL_SLOT: r_special_slot <= i_cfg_data[2:0];
                pcs_pkg::REG_HV_STATUS:    r_hv_status    <= i_cfg_data[2:0];
                pcs_pkg::REG_ALIVE_LIMIT:  r_alive_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_func(s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    pcs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_slot(s_axis_tdata[2:0]), .i_frame_id(s_axis_tdata[13:3]),
        .i_send_period(s_axis_tdata[29:14]), .i_frame_len(s_axis_tdata[33:30]),
        .i_payload(s_axis_tdata[97:34]), .i_use_alive(s_axis_tdata[98]),
        .i_use_crc(s_axis_tdata[99]), .i_now_ms(s_axis_tdata[131:100]),
        .i_fifo_space(s_axis_tdata[135:132]),
        .i_special_slot(r_special_slot), .i_hv_status(r_hv_status),
        .i_alive_limit(r_alive_limit),
        .o_frame(w_frame), .o_frame_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_frame};

    `PCS_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input accepted while result pending")
    `PCS_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tlast && m_axis_tdata[87:1] == 87'd0, "empty marker malformed")
    `PCS_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !m_axis_tvalid, "load produced a result")
endmodule
`default_nettype wire
